FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the stable priority queue.
// Holds command and status codes, level width and the cell control struct.
package spq_pkg;

    localparam int LEVEL_BITS  = 3;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int HEAD_BITS   = 16;
    localparam int ENTRY_BITS  = 16;
    localparam int OCC_BITS    = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_PEEKED = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [LEVEL_BITS-1:0] new_level;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One slot of the shift-insert chain: holds a tag and a level.
// Depends on spq_pkg for the control struct and level width.
module spq_cell #(
    parameter int TAG_BITS = 16
) (
    input  wire                           i_clk,
    input  wire spq_pkg::t_cell_ctl       i_ctl,
    input  wire [TAG_BITS-1:0]            i_new_tag,
    input  wire                           i_occ,
    input  wire                           i_left_ge,
    input  wire [TAG_BITS-1:0]            i_left_tag,
    input  wire [spq_pkg::LEVEL_BITS-1:0] i_left_level,
    input  wire [TAG_BITS-1:0]            i_right_tag,
    input  wire [spq_pkg::LEVEL_BITS-1:0] i_right_level,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic [spq_pkg::LEVEL_BITS-1:0] o_level,
    output logic                          o_ge
);

    logic [TAG_BITS-1:0]            r_tag;
    logic [spq_pkg::LEVEL_BITS-1:0] r_level;
    logic [TAG_BITS-1:0]            n_tag;
    logic [spq_pkg::LEVEL_BITS-1:0] n_level;

    assign o_ge    = i_occ && (r_level >= i_ctl.new_level);
    assign o_tag   = r_tag;
    assign o_level = r_level;

    always_comb begin
        n_tag   = r_tag;
        n_level = r_level;
        if (i_ctl.push) begin
            if (!o_ge) begin
                if (i_left_ge) begin
                    n_tag   = i_new_tag;
                    n_level = i_ctl.new_level;
                end else begin
                    n_tag   = i_left_tag;
                    n_level = i_left_level;
                end
            end
        end else if (i_ctl.pop) begin
            n_tag   = i_right_tag;
            n_level = i_right_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_level <= n_level;
    end

endmodule
`default_nettype wire

FILE: sv/stable_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Stable priority queue: higher level first, equal levels in arrival order.
// Built from a chain of spq_cell slots; depends on spq_pkg.
//
// One command is taken per clock while o_in_stall is low; its result is
// registered in the output register at the input transfer, and a new
// command is taken in the same cycle that the waiting result is taken.
// Every slot compares its own level with the arriving one and shifts by
// itself, so cost does not grow with occupancy. A push to a full queue
// reports full, a pop or peek on an empty queue empty; code 3 acts as peek.
module stable_priority_queue_top #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [spq_pkg::CMD_BITS-1:0]     i_cmd,
    input  wire [spq_pkg::ENTRY_BITS-1:0]   i_entry_tag,
    input  wire [spq_pkg::LEVEL_BITS-1:0]   i_priority_level,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [spq_pkg::STATUS_BITS-1:0] o_status,
    output logic [spq_pkg::HEAD_BITS-1:0]   o_head_tag,
    output logic [spq_pkg::OCC_BITS-1:0]    o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic                           r_out_valid;
    spq_pkg::t_status               r_status;
    spq_pkg::t_status               n_status;
    logic [spq_pkg::HEAD_BITS-1:0]  r_head_tag;
    logic [spq_pkg::HEAD_BITS-1:0]  n_head_tag;
    logic [spq_pkg::OCC_BITS-1:0]   r_occ;

    logic                           xfer_in;
    logic                           q_full;
    logic                           q_empty;
    logic [TAG_BITS-1:0]            new_tag;
    spq_pkg::t_cell_ctl             cell_ctl;

    logic [TAG_BITS-1:0]            cell_tag   [CAPACITY];
    logic [spq_pkg::LEVEL_BITS-1:0] cell_level [CAPACITY];
    logic                           cell_ge    [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign xfer_in    = i_in_valid && !o_in_stall;
    assign q_full     = (r_count == CW'(CAPACITY));
    assign q_empty    = (r_count == '0);
    assign new_tag    = TAG_BITS'(i_entry_tag);

    always_comb begin
        cell_ctl.push      = 1'b0;
        cell_ctl.pop       = 1'b0;
        cell_ctl.new_level = i_priority_level;
        n_count            = r_count;
        n_head_tag         = '0;
        n_status           = spq_pkg::ST_EMPTY;
        unique case (spq_pkg::t_cmd'(i_cmd))
            spq_pkg::CMD_PUSH: begin
                if (q_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_status      = spq_pkg::ST_PUSHED;
                    cell_ctl.push = xfer_in;
                    n_count       = r_count + CW'(1);
                end
            end
            spq_pkg::CMD_POP: begin
                if (!q_empty) begin
                    n_status     = spq_pkg::ST_POPPED;
                    n_head_tag   = spq_pkg::HEAD_BITS'(cell_tag[0]);
                    cell_ctl.pop = xfer_in;
                    n_count      = r_count - CW'(1);
                end
            end
            default: begin
                if (!q_empty) begin
                    n_status   = spq_pkg::ST_PEEKED;
                    n_head_tag = spq_pkg::HEAD_BITS'(cell_tag[0]);
                end
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                           occ;
        logic                           left_ge;
        logic [TAG_BITS-1:0]            left_tag;
        logic [spq_pkg::LEVEL_BITS-1:0] left_level;
        logic [TAG_BITS-1:0]            right_tag;
        logic [spq_pkg::LEVEL_BITS-1:0] right_level;

        assign occ = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_ge    = 1'b1;
            assign left_tag   = new_tag;
            assign left_level = i_priority_level;
        end else begin : g_body
            assign left_ge    = cell_ge[g-1];
            assign left_tag   = cell_tag[g-1];
            assign left_level = cell_level[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_tag   = cell_tag[g];
            assign right_level = cell_level[g];
        end else begin : g_inner
            assign right_tag   = cell_tag[g+1];
            assign right_level = cell_level[g+1];
        end

        spq_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_new_tag    (new_tag),
            .i_occ        (occ),
            .i_left_ge    (left_ge),
            .i_left_tag   (left_tag),
            .i_left_level (left_level),
            .i_right_tag  (right_tag),
            .i_right_level(right_level),
            .o_tag        (cell_tag[g]),
            .o_level      (cell_level[g]),
            .o_ge         (cell_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (xfer_in) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer_in) begin
            r_status   <= n_status;
            r_head_tag <= n_head_tag;
            r_occ      <= spq_pkg::OCC_BITS'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_head_tag  = r_head_tag;
    assign o_occupancy = r_occ;

endmodule
`default_nettype wire
